// ===== hw/rtl/gdt_pkg.sv =====
// Package: shared constants, codes, state types and control structs for the graph walker.
`timescale 1ns / 1ps

package gdt_pkg;

  localparam int NUM_VERTICES_DEF = 256;
  localparam int VERTEX_W         = 8;
  localparam int CMD_W            = 3;
  localparam int CHUNK            = 16;
  localparam int CHUNK_W          = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_DFS   = 3'd2,
    CMD_BFS   = 3'd3,
    CMD_STEP  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_DFS       = 2'd1,
    MODE_BFS       = 2'd2,
    MODE_DFS_START = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_DFS_TOP,
    ST_DFS_FR,
    ST_DFS_SCAN,
    ST_DFS_PUSH,
    ST_BFS_POP,
    ST_BFS_U,
    ST_BFS_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic cap_in;
    logic clr_start;
    logic clr_wr;
    logic walk_clear;
    logic dfs_start;
    logic bfs_start;
    logic add_rd_a;
    logic add_wr_a;
    logic add_wr_b;
    logic res_done;
    logic res_start;
    logic dfs_rd_top;
    logic dfs_fr;
    logic scan_adv;
    logic dfs_hit;
    logic dfs_push;
    logic dfs_pop;
    logic bfs_pop;
    logic bfs_u;
    logic bfs_enq;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic  clr_last;
    mode_t mode;
    logic  depth_zero;
    logic  q_empty;
    logic  hit;
    logic  last_chunk;
    logic  tail_full;
    logic  out_free;
  } sts_t;

  function automatic logic [CHUNK_W-1:0] prio_idx(input logic [CHUNK-1:0] bits);
    logic [CHUNK_W-1:0] idx;
    idx = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = CHUNK_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/graph_dfs_bfs_traversal_top.sv =====
// Top level of the graph walker: DFS and BFS over an adjacency bit matrix.
//
//   channel | ports    | tdata                          | tuser          | tlast
//   input   | in_*     | [7:0] vertex_a, [15:8] vertex_b | [2:0] command  | -
//   result  | out_*    | [7:0] visited_vertex           | [0] vertex_valid | walk_done
//
// Clear writes one adjacency row per cycle; reset runs the same pass before the first
// transaction. Add edge reads row a, then writes rows a and b; a start only sets up the walk.
// A DFS step reads the top frame, fetches its row, scans 16-bit chunks from the frame's
// cursor (popping exhausted frames) and pushes the hit; a BFS step pops the queue and scans
// the row's 16-bit chunks, enqueueing new neighbours; a step while idle or at a DFS start only emits.
// The scan of a row through the 16-bit priority encoder sets the step time.
// A result waits in the output register while the next transaction is taken.
`timescale 1ns / 1ps

module graph_dfs_bfs_traversal_top
  import gdt_pkg::*;
#(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] vertex_a, [15:8] vertex_b
  input  logic [2:0]  in_tuser,   // [2:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] visited_vertex
  output logic        out_tuser,  // [0] vertex_valid
  output logic        out_tlast
);

  ctl_t ctl;
  sts_t sts;

  gdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  gdt_datapath #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_a       (in_tdata[7:0]),
    .in_b       (in_tdata[15:8]),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_vertex (out_tdata),
    .out_ok     (out_tuser),
    .out_done   (out_tlast)
  );

endmodule

// ===== hw/rtl/gdt_ctrl.sv =====
// Controller: command sequencing state machine of the graph walker.
`timescale 1ns / 1ps

module gdt_ctrl
  import gdt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_tready,
  input  sts_t             sts,
  output ctl_t             ctl
);

  state_t state_r, state_nxt;
  logic   fire;

  assign in_tready = (state_r == ST_IDLE);
  assign fire      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (fire) begin
          case (in_cmd)
            CMD_CLEAR: state_nxt = ST_CLR;
            CMD_ADD:   state_nxt = ST_ADD_A;
            CMD_STEP: begin
              unique case (sts.mode)
                MODE_DFS:       state_nxt = ST_DFS_TOP;
                MODE_BFS:       state_nxt = ST_BFS_POP;
                MODE_DFS_START: state_nxt = ST_EMIT;
                MODE_IDLE:      state_nxt = ST_EMIT;
                default:        state_nxt = ST_EMIT;
              endcase
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_A:   state_nxt = ST_ADD_B;
      ST_ADD_B:   state_nxt = ST_IDLE;
      ST_DFS_TOP: state_nxt = sts.depth_zero ? ST_EMIT : ST_DFS_FR;
      ST_DFS_FR:  state_nxt = ST_DFS_SCAN;
      ST_DFS_SCAN: begin
        if (sts.hit) state_nxt = ST_DFS_PUSH;
        else if (sts.last_chunk) state_nxt = ST_DFS_TOP;
      end
      ST_DFS_PUSH: state_nxt = ST_EMIT;
      ST_BFS_POP:  state_nxt = sts.q_empty ? ST_EMIT : ST_BFS_U;
      ST_BFS_U:    state_nxt = ST_BFS_SCAN;
      ST_BFS_SCAN: begin
        if (sts.hit) begin
          if (sts.tail_full) state_nxt = ST_EMIT;
        end else if (sts.last_chunk) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_CLR: ctl.clr_wr = 1'b1;
      ST_IDLE: begin
        if (fire) begin
          ctl.cap_in = 1'b1;
          case (in_cmd)
            CMD_CLEAR: begin
              ctl.walk_clear = 1'b1;
              ctl.clr_start  = 1'b1;
            end
            CMD_ADD: ctl.add_rd_a = 1'b1;
            CMD_DFS: begin
              ctl.walk_clear = 1'b1;
              ctl.dfs_start  = 1'b1;
            end
            CMD_BFS: begin
              ctl.walk_clear = 1'b1;
              ctl.bfs_start  = 1'b1;
            end
            CMD_STEP: begin
              if (sts.mode == MODE_DFS_START) ctl.res_start = 1'b1;
              else if (sts.mode == MODE_IDLE) ctl.res_done = 1'b1;
            end
            default: ctl.cap_in = 1'b1;
          endcase
        end
      end
      ST_ADD_A: ctl.add_wr_a = 1'b1;
      ST_ADD_B: ctl.add_wr_b = 1'b1;
      ST_DFS_TOP: begin
        if (sts.depth_zero) ctl.res_done = 1'b1;
        else ctl.dfs_rd_top = 1'b1;
      end
      ST_DFS_FR: ctl.dfs_fr = 1'b1;
      ST_DFS_SCAN: begin
        if (sts.hit) ctl.dfs_hit = 1'b1;
        else if (sts.last_chunk) ctl.dfs_pop = 1'b1;
        else ctl.scan_adv = 1'b1;
      end
      ST_DFS_PUSH: ctl.dfs_push = 1'b1;
      ST_BFS_POP: begin
        if (sts.q_empty) ctl.res_done = 1'b1;
        else ctl.bfs_pop = 1'b1;
      end
      ST_BFS_U: ctl.bfs_u = 1'b1;
      ST_BFS_SCAN: begin
        if (sts.hit) begin
          if (!sts.tail_full) ctl.bfs_enq = 1'b1;
        end else if (!sts.last_chunk) begin
          ctl.scan_adv = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) ctl.load_out = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

endmodule

// ===== hw/rtl/gdt_datapath.sv =====
// Datapath: adjacency memory, walk maps, stack, queue, row scanner and result register.
`timescale 1ns / 1ps

module gdt_datapath
  import gdt_pkg::*;
#(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [VERTEX_W-1:0] in_a,
  input  logic [VERTEX_W-1:0] in_b,
  input  ctl_t                ctl,
  output sts_t                sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [VERTEX_W-1:0] out_vertex,
  output logic                out_ok,
  output logic                out_done
);

  localparam int NV   = NUM_VERTICES;
  localparam int VW   = $clog2(NV);
  localparam int CW   = $clog2(NV + 1);
  localparam int PW   = CW + CHUNK_W;
  localparam int NCH  = (NV + CHUNK - 1) / CHUNK;
  localparam int ROWP = NCH * CHUNK;
  localparam int AW   = (VW > VERTEX_W) ? VW : VERTEX_W;

  logic [NV-1:0] adj_mem [NV];
  logic [VW-1:0] stk_v_mem [NV];
  logic [CW-1:0] stk_c_mem [NV];
  logic [VW-1:0] q_mem [NV];

  logic [NV-1:0] adj_q_r;
  logic [VW-1:0] stk_v_q_r;
  logic [CW-1:0] stk_c_q_r;
  logic [VW-1:0] q_q_r;

  mode_t         mode_r;
  logic [NV-1:0] visited_r;
  logic [NV-1:0] enq_r;
  logic [CW-1:0] depth_r;
  logic [CW-1:0] head_r;
  logic [CW-1:0] tail_r;
  logic [PW-1:0] pos_r;
  logic [VW-1:0] n_r;
  logic [VW-1:0] start_v_r;
  logic [VW-1:0] res_v_r;
  logic          res_ok_r;
  logic          res_done_r;
  logic          out_valid_r;
  logic [VW-1:0] out_v_r;
  logic          out_ok_r;
  logic          out_done_r;
  logic [VW-1:0] clr_r;
  logic [VW-1:0] a_r;
  logic [VW-1:0] b_r;
  logic          edge_ok_r;

  logic [AW-1:0] a_x, b_x, res_x;
  logic          a_ok, b_ok;
  logic [VW-1:0] a_v, b_v;
  logic [VW-1:0] top;

  assign a_x  = AW'(in_a);
  assign b_x  = AW'(in_b);
  assign a_ok = (a_x <= AW'(NV - 1));
  assign b_ok = (b_x <= AW'(NV - 1));
  assign a_v  = a_x[VW-1:0];
  assign b_v  = b_x[VW-1:0];
  assign top  = VW'(depth_r - CW'(1));

  logic [ROWP-1:0]    cand, row_p, vis_p, enq_p, shifted;
  logic [PW-1:0]      base, next_base, hit_w;
  logic [CHUNK-1:0]   chunk_m;
  logic [CHUNK_W-1:0] idx;
  logic               in_range;
  logic [VW-1:0]      hit_n;

  assign row_p     = ROWP'(adj_q_r);
  assign vis_p     = ROWP'(visited_r);
  assign enq_p     = ROWP'(enq_r);
  assign cand      = (mode_r == MODE_BFS) ? (row_p & ~enq_p) : (row_p & ~vis_p);
  assign base      = {pos_r[PW-1:CHUNK_W], {CHUNK_W{1'b0}}};
  assign next_base = base + PW'(CHUNK);
  assign shifted   = cand >> base;
  assign chunk_m   = shifted[CHUNK-1:0] & ({CHUNK{1'b1}} << pos_r[CHUNK_W-1:0]);
  assign in_range  = (pos_r < PW'(NV));
  assign idx       = prio_idx(chunk_m);
  assign hit_w     = base + PW'(idx);
  assign hit_n     = hit_w[VW-1:0];

  assign sts.clr_last   = (clr_r == VW'(NV - 1));
  assign sts.mode       = mode_r;
  assign sts.depth_zero = (depth_r == '0);
  assign sts.q_empty    = (head_r >= tail_r);
  assign sts.hit        = in_range && (|chunk_m);
  assign sts.last_chunk = !in_range || (next_base >= PW'(NV));
  assign sts.tail_full  = (tail_r >= CW'(NV));
  assign sts.out_free   = !out_valid_r || out_tready;

  logic          adj_we, adj_re;
  logic [VW-1:0] adj_wa, adj_ra;
  logic [NV-1:0] adj_wd;

  always_comb begin
    adj_we = 1'b0;
    adj_wa = clr_r;
    adj_wd = '0;
    if (ctl.clr_wr) begin
      adj_we = 1'b1;
    end else if (ctl.add_wr_a) begin
      adj_we = edge_ok_r;
      adj_wa = a_r;
      adj_wd = adj_q_r | (NV'(1) << b_r);
    end else if (ctl.add_wr_b) begin
      adj_we = edge_ok_r;
      adj_wa = b_r;
      adj_wd = adj_q_r | (NV'(1) << a_r);
    end
    adj_re = ctl.add_rd_a || ctl.add_wr_a || ctl.dfs_fr || ctl.bfs_u;
    if (ctl.add_rd_a) adj_ra = a_v;
    else if (ctl.add_wr_a) adj_ra = b_r;
    else if (ctl.dfs_fr) adj_ra = stk_v_q_r;
    else adj_ra = q_q_r;
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    if (adj_re) adj_q_r <= adj_mem[adj_ra];
  end

  logic          stk_v_we, stk_c_we;
  logic [VW-1:0] stk_wa, stk_wv;
  logic [CW-1:0] stk_wc;

  always_comb begin
    stk_v_we = 1'b0;
    stk_c_we = 1'b0;
    stk_wa   = '0;
    stk_wv   = a_v;
    stk_wc   = '0;
    if (ctl.dfs_start) begin
      stk_v_we = a_ok;
      stk_c_we = a_ok;
    end else if (ctl.dfs_hit) begin
      stk_c_we = 1'b1;
      stk_wa   = top;
      stk_wc   = CW'(hit_w + PW'(1));
    end else if (ctl.dfs_push) begin
      stk_v_we = (depth_r < CW'(NV));
      stk_c_we = (depth_r < CW'(NV));
      stk_wa   = depth_r[VW-1:0];
      stk_wv   = n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_v_we) stk_v_mem[stk_wa] <= stk_wv;
    if (stk_c_we) stk_c_mem[stk_wa] <= stk_wc;
    if (ctl.dfs_rd_top) begin
      stk_v_q_r <= stk_v_mem[top];
      stk_c_q_r <= stk_c_mem[top];
    end
  end

  logic          q_we;
  logic [VW-1:0] q_wa, q_wd;

  always_comb begin
    q_we = 1'b0;
    q_wa = '0;
    q_wd = a_v;
    if (ctl.bfs_start) begin
      q_we = a_ok;
    end else if (ctl.bfs_enq) begin
      q_we = 1'b1;
      q_wa = tail_r[VW-1:0];
      q_wd = hit_n;
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    if (ctl.bfs_pop) q_q_r <= q_mem[head_r[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_in) begin
      a_r       <= a_v;
      b_r       <= b_v;
      edge_ok_r <= a_ok && b_ok;
    end
    if (ctl.dfs_fr) pos_r <= PW'(stk_c_q_r);
    else if (ctl.bfs_u) pos_r <= '0;
    else if (ctl.scan_adv) pos_r <= next_base;
    else if (ctl.bfs_enq) pos_r <= hit_w + PW'(1);
    if (ctl.dfs_hit) n_r <= hit_n;
    if (ctl.dfs_start) start_v_r <= a_v;
    if (ctl.res_done) begin
      res_v_r    <= '0;
      res_ok_r   <= 1'b0;
      res_done_r <= 1'b1;
    end else if (ctl.res_start) begin
      res_v_r    <= start_v_r;
      res_ok_r   <= 1'b1;
      res_done_r <= 1'b0;
    end else if (ctl.dfs_hit) begin
      res_v_r    <= hit_n;
      res_ok_r   <= 1'b1;
      res_done_r <= 1'b0;
    end else if (ctl.bfs_u) begin
      res_v_r    <= q_q_r;
      res_ok_r   <= 1'b1;
      res_done_r <= 1'b0;
    end
    if (ctl.load_out) begin
      out_v_r    <= res_v_r;
      out_ok_r   <= res_ok_r;
      out_done_r <= res_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      visited_r   <= '0;
      enq_r       <= '0;
      depth_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.clr_start) clr_r <= '0;
      else if (ctl.clr_wr) clr_r <= sts.clr_last ? '0 : clr_r + VW'(1);
      if (ctl.walk_clear) begin
        mode_r    <= MODE_IDLE;
        visited_r <= '0;
        enq_r     <= '0;
        depth_r   <= '0;
        head_r    <= '0;
        tail_r    <= '0;
      end
      if (ctl.dfs_start) begin
        if (a_ok) begin
          visited_r[a_v] <= 1'b1;
          depth_r        <= CW'(1);
          mode_r         <= MODE_DFS_START;
        end else begin
          mode_r <= MODE_DFS;
        end
      end
      if (ctl.bfs_start) begin
        mode_r <= MODE_BFS;
        if (a_ok) begin
          enq_r[a_v] <= 1'b1;
          tail_r     <= CW'(1);
        end
      end
      if (ctl.res_done) begin
        mode_r  <= MODE_IDLE;
        depth_r <= '0;
      end
      if (ctl.res_start) mode_r <= MODE_DFS;
      if (ctl.dfs_hit) visited_r[hit_n] <= 1'b1;
      if (ctl.dfs_push && (depth_r < CW'(NV))) depth_r <= depth_r + CW'(1);
      if (ctl.dfs_pop) depth_r <= depth_r - CW'(1);
      if (ctl.bfs_pop) head_r <= head_r + CW'(1);
      if (ctl.bfs_u) visited_r[q_q_r] <= 1'b1;
      if (ctl.bfs_enq) begin
        enq_r[hit_n] <= 1'b1;
        tail_r       <= tail_r + CW'(1);
      end
      if (ctl.load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign res_x      = AW'(out_v_r);
  assign out_tvalid = out_valid_r;
  assign out_vertex = res_x[VERTEX_W-1:0];
  assign out_ok     = out_ok_r;
  assign out_done   = out_done_r;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the graph walker: directed and random command streams checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import gdt_pkg::*;

  localparam int NV = 256;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  typedef struct packed {
    logic [7:0] vertex;
    logic       valid;
    logic       done;
  } visit_t;

  graph_dfs_bfs_traversal_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // walker model state
  logic [NV-1:0] adj [NV];
  logic [NV-1:0] seen;
  logic [NV-1:0] queued;
  logic [7:0]    stk_v [NV];
  int            stk_c [NV];
  int            depth;
  logic [7:0]    bq [NV];
  int            head;
  int            tail;
  mode_t         mode;

  visit_t expected_visits[$];
  int     errors = 0;
  bit     idle_out = 1'b0;

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  task automatic reset_walk();
    seen = '0; queued = '0; depth = 0; head = 0; tail = 0; mode = MODE_IDLE;
  endtask

  function automatic visit_t mk(logic [7:0] v, logic val, logic dn);
    visit_t r;
    r.vertex = v; r.valid = val; r.done = dn;
    return r;
  endfunction

  task automatic add_visit(input visit_t v);
    expected_visits = {expected_visits, v};
  endtask

  task automatic predict_walk(input cmd_t cmd, input logic [7:0] a, input logic [7:0] b);
    int n;
    int u;
    bit found;
    case (cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < NV; i++) adj[i] = '0;
        reset_walk();
      end
      CMD_ADD: begin
        adj[a][b] = 1'b1;
        adj[b][a] = 1'b1;
      end
      CMD_DFS: begin
        reset_walk();
        seen[a] = 1'b1; stk_v[0] = a; stk_c[0] = 0; depth = 1;
        mode = MODE_DFS_START;
      end
      CMD_BFS: begin
        reset_walk();
        queued[a] = 1'b1; bq[0] = a; tail = 1;
        mode = MODE_BFS;
      end
      CMD_STEP: begin
        if (mode == MODE_DFS_START) begin
          mode = MODE_DFS;
          add_visit(mk(stk_v[0], 1'b1, 1'b0));
        end else if (mode == MODE_DFS) begin
          found = 0;
          while (depth > 0 && !found) begin
            u = stk_v[depth-1];
            for (n = stk_c[depth-1]; n < NV; n++)
              if (adj[u][n] && !seen[n]) break;
            if (n < NV) begin
              found = 1;
              stk_c[depth-1] = n + 1;
              seen[n] = 1'b1;
              if (depth < NV) begin
                stk_v[depth] = n[7:0]; stk_c[depth] = 0; depth++;
              end
              add_visit(mk(n[7:0], 1'b1, 1'b0));
            end else begin
              depth--;
            end
          end
          if (!found) begin
            depth = 0; mode = MODE_IDLE;
            add_visit(mk(8'd0, 1'b0, 1'b1));
          end
        end else if (mode == MODE_BFS) begin
          if (head >= tail) begin
            mode = MODE_IDLE;
            add_visit(mk(8'd0, 1'b0, 1'b1));
          end else begin
            u = bq[head]; head++;
            seen[u] = 1'b1;
            for (n = 0; n < NV; n++)
              if (adj[u][n] && !queued[n] && tail < NV) begin
                queued[n] = 1'b1; bq[tail] = n[7:0]; tail++;
              end
            add_visit(mk(u[7:0], 1'b1, 1'b0));
          end
        end else begin
          add_visit(mk(8'd0, 1'b0, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_command(input logic [2:0] cmd, input logic [7:0] a,
                              input logic [7:0] b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_walk(cmd_t'(cmd), a, b);
  endtask

  task automatic hold_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    hold_input();
    while (expected_visits.size() != 0) @(posedge clk);
    repeat (NV + 50) @(posedge clk);
  endtask

  always @(posedge clk) begin
    visit_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_visits.size() == 0) begin
        $error("unexpected result vertex=%0d", out_tdata);
        errors++;
      end else begin
        e = expected_visits.pop_front();
        if (out_tdata !== e.vertex) begin
          $error("visited_vertex expected %0d got %0d", e.vertex, out_tdata); errors++;
        end
        if (out_tuser !== e.valid) begin
          $error("vertex_valid expected %0d got %0d", e.valid, out_tuser); errors++;
        end
        if (out_tlast !== e.done) begin
          $error("walk_done expected %0d got %0d", e.done, out_tlast); errors++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (idle_out || stall_left == 0) begin
      out_tready <= 1'b1;
      if (!idle_out && out_tvalid && out_tready)
        stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
    end else begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  task automatic test_directed();
    send_command(CMD_STEP, 8'd0, 8'd0);
    send_command(CMD_ADD, 8'd0, 8'd255);
    send_command(CMD_ADD, 8'd255, 8'd0);
    send_command(CMD_ADD, 8'd7, 8'd7);
    send_command(CMD_ADD, 8'd0, 8'd7);
    send_command(CMD_ADD, 8'd255, 8'd128);
    send_command(3'd5, 8'd1, 8'd2);
    send_command(3'd7, 8'd255, 8'd255);
    send_command(CMD_DFS, 8'd0, 8'd0);
    repeat (5) send_command(CMD_STEP, 8'd0, 8'd0);
    send_command(CMD_BFS, 8'd255, 8'd0);
    send_command(CMD_STEP, 8'd0, 8'd0);
    send_command(CMD_ADD, 8'd128, 8'd64);
    send_command(CMD_DFS, 8'd7, 8'd0);
    send_command(CMD_STEP, 8'd0, 8'd0);
    send_command(CMD_CLEAR, 8'd0, 8'd0);
    send_command(CMD_STEP, 8'd0, 8'd0);
  endtask

  task automatic test_random_walks();
    int items;
    int k;
    logic [7:0] base;
    items = 0;
    while (items < 2000) begin
      base = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 15));
      if ($urandom_range(0, 4) == 0) begin
        send_command(CMD_CLEAR, 8'($urandom), 8'($urandom)); items++;
      end
      k = $urandom_range(1, 20);
      repeat (k) begin
        send_command(CMD_ADD, base ^ 8'($urandom_range(0, 15)),
                     $urandom_range(0, 7) == 0 ? 8'($urandom) : base ^ 8'($urandom_range(0, 15)));
        items++;
      end
      send_command($urandom_range(0, 1) ? CMD_DFS : CMD_BFS, base ^ 8'($urandom_range(0, 3)),
                   8'($urandom));
      items++;
      k = $urandom_range(1, 25);
      repeat (k) begin
        case ($urandom_range(0, 19))
          0: send_command(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom));
          1: send_command(CMD_ADD, 8'($urandom), 8'($urandom));
          2: send_command($urandom_range(0, 1) ? CMD_DFS : CMD_BFS, 8'($urandom), 8'($urandom));
          default: send_command(CMD_STEP, 8'($urandom), 8'($urandom));
        endcase
        items++;
      end
      if ($urandom_range(0, 30) == 0) begin
        hold_input();
        while (expected_visits.size() != 0) @(posedge clk);
      end
    end
  endtask

  task automatic test_sender_hold();
    send_command(CMD_BFS, 8'd0, 8'd0);
    repeat (4) send_command(CMD_STEP, 8'd0, 8'd0);
    hold_input();
    while (expected_visits.size() != 0) @(posedge clk);
    repeat (3) send_command(CMD_STEP, 8'd0, 8'd0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    for (int i = 0; i < NV; i++) adj[i] = '0;
    reset_walk();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_sender_hold();
    test_random_walks();
    idle_out = 1'b1;
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #400ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/gdt_pkg.sv
hw/rtl/gdt_ctrl.sv
hw/rtl/gdt_datapath.sv
hw/rtl/graph_dfs_bfs_traversal_top.sv
bench/tb_top.sv
